[rtl/core/skt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table: operation and status codes.
// ----------------------------------------------------------------------------
package skt_pkg;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_INSERT = 2'd0;
    localparam t_op OP_SEARCH = 2'd1;
    localparam t_op OP_DELETE = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

endpackage

[rtl/core/skt_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/skt_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_seq
// Operation sequencer: scans the key memory for the lower bound; for insert and
// delete it then shifts entries up or down one word at a time, and insert writes the new key.
// ----------------------------------------------------------------------------
module skt_seq #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32,
    localparam int IW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  skt_pkg::t_op         i_op,
    input  logic [KEY_WIDTH-1:0] i_key,
    output logic                 busy,
    output logic                 o_done,
    output skt_pkg::t_status     o_status,
    output logic [3:0]           o_position,
    output logic [4:0]           o_entry_count,
    output logic                 o_mem_we,
    output logic [IW-1:0]        o_mem_waddr,
    output logic [KEY_WIDTH-1:0] o_mem_wdata,
    output logic [IW-1:0]        o_mem_raddr,
    input  logic [KEY_WIDTH-1:0] i_mem_rdata
);
    import skt_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN_RD  = 3'd1;
    localparam logic [2:0] S_SCAN_CMP = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_SHIFT_RD = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_WRITE    = 3'd6;

    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_j, n_j;
    logic                 r_eq, n_eq;
    t_op                  r_op, n_op;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic                 r_done, n_done;
    t_status              r_status, n_status;
    logic [CW-1:0]        r_pos, n_pos;

    logic [CW-1:0]        w_jm1;
    logic [CW-1:0]        w_jp1;
    logic [CW:0]          w_jp2;
    logic [CW:0]          w_idxp1;
    logic [CW+3:0]        w_pos_ext;
    logic [CW+4:0]        w_cnt_ext;

    assign w_jm1   = r_j - 1'b1;
    assign w_jp1   = r_j + 1'b1;
    assign w_jp2   = {1'b0, r_j} + (CW+1)'(2);
    assign w_idxp1 = {1'b0, r_idx} + (CW+1)'(1);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_j         = r_j;
        n_eq        = r_eq;
        n_op        = r_op;
        n_key       = r_key;
        n_done      = 1'b0;
        n_status    = r_status;
        n_pos       = r_pos;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_j[IW-1:0];
        o_mem_wdata = i_mem_rdata;
        o_mem_raddr = r_idx[IW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_op;
                    n_key = i_key;
                    n_idx = '0;
                    if (i_op == OP_INSERT && r_count >= FULL_CNT) begin
                        n_done   = 1'b1;
                        n_status = ST_FULL;
                        n_pos    = '0;
                    end else if (i_op == OP_INSERT || i_op == OP_SEARCH ||
                                 i_op == OP_DELETE) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_done   = 1'b1;
                        n_status = ST_NOT_FOUND;
                        n_pos    = '0;
                    end
                end
            end
            S_SCAN_RD: begin
                if (r_idx >= r_count) begin
                    n_eq    = 1'b0;
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_mem_rdata < r_key) begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SCAN_RD;
                end else begin
                    n_eq    = (i_mem_rdata == r_key);
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                case (r_op)
                    OP_INSERT: begin
                        n_j     = r_count;
                        n_state = (r_count > r_idx) ? S_SHIFT_RD : S_WRITE;
                    end
                    OP_DELETE: begin
                        if (!r_eq) begin
                            n_done   = 1'b1;
                            n_status = ST_NOT_FOUND;
                            n_pos    = '0;
                            n_state  = S_IDLE;
                        end else if (w_idxp1 < {1'b0, r_count}) begin
                            n_j     = r_idx;
                            n_state = S_SHIFT_RD;
                        end else begin
                            n_count  = r_count - 1'b1;
                            n_done   = 1'b1;
                            n_status = ST_OK;
                            n_pos    = r_idx;
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        n_done   = 1'b1;
                        n_status = r_eq ? ST_OK : ST_NOT_FOUND;
                        n_pos    = r_eq ? r_idx : '0;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                o_mem_raddr = (r_op == OP_INSERT) ? w_jm1[IW-1:0] : w_jp1[IW-1:0];
                n_state     = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_j[IW-1:0];
                o_mem_wdata = i_mem_rdata;
                if (r_op == OP_INSERT) begin
                    n_j     = w_jm1;
                    n_state = (w_jm1 == r_idx) ? S_WRITE : S_SHIFT_RD;
                end else begin
                    n_j = w_jp1;
                    if (w_jp2 >= {1'b0, r_count}) begin
                        n_count  = r_count - 1'b1;
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_pos    = r_idx;
                        n_state  = S_IDLE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_WRITE: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_idx[IW-1:0];
                o_mem_wdata = r_key;
                n_count     = r_count + 1'b1;
                n_done      = 1'b1;
                n_status    = ST_OK;
                n_pos       = r_idx;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_j      <= n_j;
        r_eq     <= n_eq;
        r_op     <= n_op;
        r_key    <= n_key;
        r_status <= n_status;
        r_pos    <= n_pos;
    end

    assign w_pos_ext     = {4'b0, r_pos};
    assign w_cnt_ext     = {5'b0, r_count};
    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_position    = w_pos_ext[3:0];
    assign o_entry_count = w_cnt_ext[4:0];

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> r_done)
        else $error("entry count changed without a result");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_status == ST_FULL) |-> (r_count == FULL_CNT))
        else $error("full status with free entries");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result while an operation is still running");
`endif

endmodule

[rtl/core/sorted_key_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Sorted key table: insert, search and delete on keys kept in ascending order.
//
// Input: a word (i_op, i_key) is taken at a clock edge where start is high
// and busy is low. busy stays high while the operation runs.
// Output: one result word per input word, shown for exactly one cycle while
// o_done is high (o_status, o_position, o_entry_count). The receiver cannot
// stall; every result must be taken in the cycle it appears.
// Sequence: an insert into a full table or an unused op code shows its
// result in the cycle after acceptance. Otherwise the scan makes one memory
// read and one compare per stored key below the key, then either a check
// past the last key or a read and compare on the key it stops on, and a
// decision step; insert and delete add a read and a write on the key memory
// per entry moved, insert one more step for the key write, and the
// result strobe follows in the next cycle. busy is low in the strobe
// cycle, so a new word can be taken at the edge that ends it.
// Reset: synchronous, active low; the table comes out empty. Key memory
// contents are not cleared, entries above the count are never used.
// ----------------------------------------------------------------------------
module sorted_key_table_top #(
    parameter int TABLE_DEPTH = 16,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  skt_pkg::t_op         i_op,
    input  logic [KEY_WIDTH-1:0] i_key,
    output logic                 busy,
    output logic                 o_done,
    output skt_pkg::t_status     o_status,
    output logic [3:0]           o_position,
    output logic [4:0]           o_entry_count
);
    import skt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);

    logic                 w_mem_we;
    logic [IW-1:0]        w_mem_waddr;
    logic [KEY_WIDTH-1:0] w_mem_wdata;
    logic [IW-1:0]        w_mem_raddr;
    logic [KEY_WIDTH-1:0] w_mem_rdata;

    skt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .i_op          (i_op),
        .i_key         (i_key),
        .busy          (busy),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_position    (o_position),
        .o_entry_count (o_entry_count),
        .o_mem_we      (w_mem_we),
        .o_mem_waddr   (w_mem_waddr),
        .o_mem_wdata   (w_mem_wdata),
        .o_mem_raddr   (w_mem_raddr),
        .i_mem_rdata   (w_mem_rdata)
    );

    skt_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

endmodule

[tb/sorted_key_table_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_top_test
// Self-checking bench for the sorted key table. A scoreboard keeps its own
// ordered copy of the table and predicts status, position and count for
// every accepted word. Directed words cover the empty table, duplicates, the
// key extremes, a full table and the unused op code. Random words then run
// fill and drain phases with keys that often hit stored entries.
// ----------------------------------------------------------------------------
module sorted_key_table_top_test;
    import skt_pkg::*;

    localparam int  DEPTH       = 16;
    localparam int  KEY_BITS    = 32;
    localparam int  WORD_TARGET = 1050;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  TAIL_CYCLES = 100;
    localparam t_op OP_UNUSED   = 2'd3;

    typedef struct {
        t_status    status;
        logic [3:0] position;
        logic [4:0] entry_count;
    } t_answer;

    class key_table_book;
        logic [KEY_BITS-1:0] keys [DEPTH];
        int                  stored;
        t_answer             answers [$];
        int                  errors;

        function new();
            stored = 0;
            errors = 0;
        endfunction

        function int first_not_less(logic [KEY_BITS-1:0] key);
            int idx;
            idx = 0;
            while (idx < stored && keys[idx] < key) idx++;
            return idx;
        endfunction

        function void note_word(t_op op, logic [KEY_BITS-1:0] key);
            t_answer ans;
            int      idx;
            ans.status   = ST_NOT_FOUND;
            ans.position = '0;
            idx = first_not_less(key);
            case (op)
                OP_INSERT: begin
                    if (stored >= DEPTH) begin
                        ans.status = ST_FULL;
                    end else begin
                        for (int j = stored; j > idx; j--) keys[j] = keys[j-1];
                        keys[idx]    = key;
                        stored++;
                        ans.status   = ST_OK;
                        ans.position = idx[3:0];
                    end
                end
                OP_SEARCH: begin
                    if (idx < stored && keys[idx] == key) begin
                        ans.status   = ST_OK;
                        ans.position = idx[3:0];
                    end
                end
                OP_DELETE: begin
                    if (idx < stored && keys[idx] == key) begin
                        for (int j = idx; j + 1 < stored; j++) keys[j] = keys[j+1];
                        stored--;
                        ans.status   = ST_OK;
                        ans.position = idx[3:0];
                    end
                end
                default: begin
                end
            endcase
            ans.entry_count = stored[4:0];
            answers.push_back(ans);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("%0t ERROR: %s", $time, msg);
        endtask

        task check_word(t_status status, logic [3:0] position, logic [4:0] entry_count);
            t_answer want;
            if (answers.size() == 0) begin
                report_mismatch("result word with no word pending");
                return;
            end
            want = answers.pop_front();
            if (status !== want.status)
                report_mismatch($sformatf("status got %0d expected %0d",
                                          status, want.status));
            if (position !== want.position)
                report_mismatch($sformatf("position got %0d expected %0d",
                                          position, want.position));
            if (entry_count !== want.entry_count)
                report_mismatch($sformatf("entry_count got %0d expected %0d",
                                          entry_count, want.entry_count));
        endtask

        task check_drained();
            if (answers.size() != 0)
                report_mismatch($sformatf("%0d result words never arrived",
                                          answers.size()));
        endtask

        function int pending();
            return answers.size();
        endfunction

        function logic [KEY_BITS-1:0] stored_key();
            return keys[$urandom_range(stored - 1, 0)];
        endfunction
    endclass

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    t_op                 i_op    = OP_INSERT;
    logic [KEY_BITS-1:0] i_key   = '0;
    logic                busy;
    logic                o_done;
    t_status             o_status;
    logic [3:0]          o_position;
    logic [4:0]          o_entry_count;

    key_table_book book = new();
    int            cycle_count = 0;

    sorted_key_table_top #(
        .TABLE_DEPTH(DEPTH),
        .KEY_WIDTH  (KEY_BITS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_op         (i_op),
        .i_key        (i_key),
        .busy         (busy),
        .o_done       (o_done),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_entry_count(o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) book.note_word(i_op, i_key);
            if (o_done) book.check_word(o_status, o_position, o_entry_count);
        end
    end

    task automatic send_word(t_op op, logic [KEY_BITS-1:0] key, int gap, bit drain);
        if (gap > 0 || drain) start <= 1'b0;
        if (drain) begin
            @(posedge i_clk);
            while (book.pending() != 0) @(posedge i_clk);
        end
        repeat (gap) @(posedge i_clk);
        start <= 1'b1;
        i_op  <= op;
        i_key <= key;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 40 && book.stored > 0) return book.stored_key();
        if (roll < 70) return $urandom_range(15, 0);
        if (roll < 75) return $urandom_range(3, 0);
        if (roll < 80) return '1 - $urandom_range(3, 0);
        return $urandom();
    endfunction

    function automatic t_op pick_op(bit filling);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 3) return OP_UNUSED;
        if (roll < (filling ? 60 : 25)) return OP_INSERT;
        if (roll < (filling ? 78 : 45)) return OP_SEARCH;
        return OP_DELETE;
    endfunction

    initial begin
        int  real_words;
        int  n;
        int  gap;
        bit  filling;
        bit  quiet;
        t_op op;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, unused op code, extremes and duplicates
        send_word(OP_SEARCH, 32'd5, 0, 0);
        send_word(OP_DELETE, 32'd5, 0, 0);
        send_word(OP_UNUSED, '1, 0, 0);
        send_word(OP_INSERT, '1, 0, 0);
        send_word(OP_INSERT, '0, 1, 0);
        send_word(OP_INSERT, '0, 0, 0);
        send_word(OP_INSERT, 32'h8000_0000, 3, 0);
        send_word(OP_SEARCH, '0, 0, 0);
        send_word(OP_SEARCH, '1, 0, 0);
        send_word(OP_DELETE, '0, 0, 0);
        send_word(OP_DELETE, 32'd7, 0, 0);
        // fill up, then one insert too many
        for (n = 0; n < 13; n++) send_word(OP_INSERT, $urandom(), $urandom_range(2, 0), 0);
        send_word(OP_INSERT, 32'd9, 0, 0);
        send_word(OP_DELETE, '1, 0, 0);

        real_words = 0;
        n          = 0;
        filling    = 1'b1;
        quiet      = 1'b0;
        while (real_words < WORD_TARGET) begin
            if (n % 80 == 79) filling = ($urandom_range(1, 0) == 1);
            if (n % 40 == 0) quiet = ($urandom_range(3, 0) == 0);
            gap = quiet ? 0 : $urandom_range(18, 0);
            op  = pick_op(filling);
            send_word(op, pick_key(), gap, (n % 300 == 0));
            if (op != OP_UNUSED) real_words++;
            n++;
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        book.check_drained();
        if (book.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
